/* hw/rtl/hscc_pkg.sv */
// shared types and constants of the huber soft constraint cost block
`default_nettype none

package hscc_pkg;

   // fixed field widths
   localparam int DATA_W      = 32;
   localparam int WIDTH_W     = 31;
   localparam int N_W         = 33;
   localparam int U_MAG_W     = 33;
   localparam int COST_W      = 31;
   localparam int PRIO_W      = 17;
   localparam int CSR_INDEX_W = 2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BOUND = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_UPPER = 2'd2;

   // region of the normalised state
   typedef enum logic [1:0] {
      REGION_LINEAR,
      REGION_QUAD,
      REGION_ZERO
   } region_type;

   // configuration as seen by the datapath
   typedef struct packed {
      logic signed [DATA_W-1:0] bound;
      logic [WIDTH_W-1:0]       width;
      logic                     upper;
   } cfg_type;

   // payload carried alongside the first divider
   typedef struct packed {
      logic                     neg;
      logic signed [DATA_W-1:0] state_deriv;
      logic signed [DATA_W-1:0] bound_deriv;
      logic signed [DATA_W-1:0] width_deriv;
      logic                     last_elem;
   } front_tag_type;

   // queue entry between front and back
   typedef struct packed {
      logic signed [N_W-1:0]    n_val;
      region_type               region;
      logic signed [DATA_W-1:0] state_deriv;
      logic signed [DATA_W-1:0] bound_deriv;
      logic signed [DATA_W-1:0] width_deriv;
      logic                     last_elem;
   } entry_type;

   // payload carried alongside the second divider
   typedef struct packed {
      logic               u_neg;
      region_type         region;
      logic [COST_W-1:0]  cost;
      logic [PRIO_W-1:0]  prio;
      logic               last_elem;
   } back_tag_type;

endpackage

`default_nettype wire

/* hw/rtl/hscc_div.sv */
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module hscc_div #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 31,
   parameter int TAG_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [TAG_W-1:0] in_tag,
   input  logic [DEN_W-1:0] den,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quo,
   output logic [TAG_W-1:0] out_tag
);

   logic             valid_ff [NUM_W];
   logic             valid_in [NUM_W];
   logic [DEN_W-1:0] rem_ff   [NUM_W];
   logic [DEN_W-1:0] rem_in   [NUM_W];
   logic [DEN_W-1:0] rem_src  [NUM_W];
   logic [NUM_W-1:0] nq_ff    [NUM_W];
   logic [NUM_W-1:0] nq_in    [NUM_W];
   logic [NUM_W-1:0] nq_src   [NUM_W];
   logic [TAG_W-1:0] tag_ff   [NUM_W];
   logic [TAG_W-1:0] tag_in   [NUM_W];

   genvar k;
   generate
      for (k = 0; k < NUM_W; k++) begin : g_stage
         logic [DEN_W:0] trial;
         logic           take;

         // stage source: ports for the first stage, previous stage otherwise
         if (k == 0) begin : g_first
            assign valid_in[k] = in_valid;
            assign rem_src[k]  = '0;
            assign nq_src[k]   = in_num;
            assign tag_in[k]   = in_tag;
         end else begin : g_next
            assign valid_in[k] = valid_ff[k-1];
            assign rem_src[k]  = rem_ff[k-1];
            assign nq_src[k]   = nq_ff[k-1];
            assign tag_in[k]   = tag_ff[k-1];
         end

         // shift in the next numerator bit and try a subtract
         assign trial     = {rem_src[k], nq_src[k][NUM_W-1]};
         assign take      = (trial >= {1'b0, den});
         assign rem_in[k] = take ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
         assign nq_in[k]  = {nq_src[k][NUM_W-2:0], take};

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else begin
               valid_ff[k] <= valid_in[k];
            end
         end

         always_ff @(posedge clock) begin
            rem_ff[k] <= rem_in[k];
            nq_ff[k]  <= nq_in[k];
            tag_ff[k] <= tag_in[k];
         end
      end
   endgenerate

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo   = nq_ff[NUM_W-1];
   assign out_tag   = tag_ff[NUM_W-1];

   // every beat moves through the stage registers in order and leaves the last stage
   a_div_latency: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> ##NUM_W out_valid)
      else $error("divider lost a beat");

endmodule

`default_nettype wire

/* hw/rtl/hscc_fifo.sv */
// short queue between the front and back parts
`default_nettype none

module hscc_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hscc_pkg::entry_type push_data,
   input  logic                pop,
   output hscc_pkg::entry_type head,
   output logic                empty,
   output logic                full
);

   import hscc_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = CNT_W'(count_ff + 1'b1);
         2'b01:   count_in = CNT_W'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // the front cannot stall, so a push into a full queue would drop a beat
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("queue overflow");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count out of range");

endmodule

`default_nettype wire

/* hw/rtl/hscc_front.sv */
// front part: takes items, normalises the state and classifies the region
`default_nettype none

module hscc_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic signed [hscc_pkg::DATA_W-1:0]  state_value,
   input  logic signed [hscc_pkg::DATA_W-1:0]  state_deriv,
   input  logic signed [hscc_pkg::DATA_W-1:0]  bound_deriv,
   input  logic signed [hscc_pkg::DATA_W-1:0]  width_deriv,
   input  logic                                last_elem,
   input  hscc_pkg::cfg_type                   cfg,
   output logic                                push,
   output hscc_pkg::entry_type                 push_data
);

   import hscc_pkg::*;

   localparam int NUM_W = DATA_W + FRAC_BITS;
   localparam int TAG_W = $bits(front_tag_type);
   localparam logic [DATA_W-1:0] ONE   = DATA_W'(1) << FRAC_BITS;
   localparam logic [DATA_W-1:0] N_MAX = '1;

   logic [DATA_W:0]      diff;
   logic [DATA_W-1:0]    diff_mag;
   logic                 f0_valid_ff;
   logic [DATA_W-1:0]    f0_mag_ff;
   front_tag_type        f0_tag_ff, f0_tag_in;
   logic                 div_valid;
   logic [NUM_W-1:0]     div_quo;
   logic [TAG_W-1:0]     div_tag_bits;
   front_tag_type        div_tag;
   logic [DATA_W-1:0]    n_mag;
   logic                 push_ff;
   entry_type            data_ff, data_in;

   // state minus bound, as sign and magnitude
   assign diff     = {state_value[DATA_W-1], state_value} - {cfg.bound[DATA_W-1], cfg.bound};
   assign diff_mag = diff[DATA_W] ? DATA_W'(~diff + 1'b1) : diff[DATA_W-1:0];

   always_comb begin
      f0_tag_in.neg         = diff[DATA_W] ^ cfg.upper;
      f0_tag_in.state_deriv = state_deriv;
      f0_tag_in.bound_deriv = bound_deriv;
      f0_tag_in.width_deriv = width_deriv;
      f0_tag_in.last_elem   = last_elem;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_valid_ff <= 1'b0;
      end else begin
         f0_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      f0_mag_ff <= diff_mag;
      f0_tag_ff <= f0_tag_in;
   end

   // magnitude of the scaled difference over the width
   hscc_div #(
      .NUM_W (NUM_W),
      .DEN_W (WIDTH_W),
      .TAG_W (TAG_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f0_valid_ff),
      .in_num    ({f0_mag_ff, {FRAC_BITS{1'b0}}}),
      .in_tag    (f0_tag_ff),
      .den       (cfg.width),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_tag   (div_tag_bits)
   );

   assign div_tag = front_tag_type'(div_tag_bits);

   // saturate, apply the sign and pick the region
   assign n_mag = (|div_quo[NUM_W-1:DATA_W]) ? N_MAX : div_quo[DATA_W-1:0];

   always_comb begin
      data_in.n_val       = div_tag.neg ? N_W'({1'b0, N_MAX} - {1'b0, N_MAX} - {1'b0, n_mag})
                                        : {1'b0, n_mag};
      data_in.state_deriv = div_tag.state_deriv;
      data_in.bound_deriv = div_tag.bound_deriv;
      data_in.width_deriv = div_tag.width_deriv;
      data_in.last_elem   = div_tag.last_elem;
      if (div_tag.neg && (n_mag != '0)) begin
         data_in.region = REGION_LINEAR;
      end else if (n_mag < ONE) begin
         data_in.region = REGION_QUAD;
      end else begin
         data_in.region = REGION_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         push_ff <= 1'b0;
      end else begin
         push_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign push      = push_ff;
   assign push_data = data_ff;

endmodule

`default_nettype wire

/* hw/rtl/hscc_back.sv */
// back part: chain rule, cost, jacobian division and output register
`default_nettype none

module hscc_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                empty,
   input  hscc_pkg::entry_type                 head,
   input  hscc_pkg::cfg_type                   cfg,
   output logic                                pop,
   output logic                                rsp_valid,
   output logic [hscc_pkg::COST_W-1:0]         rsp_cost,
   output logic signed [hscc_pkg::DATA_W-1:0]  rsp_cost_deriv,
   output logic [hscc_pkg::PRIO_W-1:0]         rsp_norm_sat,
   output logic                                rsp_last_out
);

   import hscc_pkg::*;

   localparam int M_W    = FRAC_BITS + 1;
   localparam int PROD_W = N_W + DATA_W;
   localparam int U_W    = PROD_W + 1;
   localparam int MU_W   = U_MAG_W + FRAC_BITS;
   localparam int P_W    = (M_W > PRIO_W) ? M_W : PRIO_W;
   localparam int LIN_W  = DATA_W + 3;
   localparam int SQ_W   = 2 * M_W;
   localparam int TAG_W  = $bits(back_tag_type);
   localparam int BACK_LAT = MU_W + 4;

   localparam logic [M_W-1:0]     M_ONE    = M_W'(1) << FRAC_BITS;
   localparam logic [P_W-1:0]     PRIO_MAX = P_W'(2 ** PRIO_W - 1);
   localparam logic [LIN_W-1:0]   LIN_ONE  = LIN_W'(1) << FRAC_BITS;
   localparam logic [COST_W-1:0]  COST_MAX = '1;
   localparam logic [U_MAG_W-1:0] U_MAX    = '1;
   localparam logic [MU_W-1:0]    Q_LIM_W  = MU_W'(1) << DATA_W;
   localparam logic [DATA_W:0]    Q_LIM    = (DATA_W + 1)'(1) << DATA_W;
   localparam logic [DATA_W+1:0]  JPOS_MAX = (DATA_W + 2)'(2 ** (DATA_W - 1) - 1);
   localparam logic [DATA_W+1:0]  JNEG_MAX = (DATA_W + 2)'(1) << (DATA_W - 1);

   // stage 1: state jacobian product, derivative difference, m and priority
   logic                      b1_valid_ff;
   logic signed [PROD_W-1:0]  b1_prod_ff, b1_prod_in;
   logic signed [DATA_W:0]    b1_dsb_ff, b1_dsb_in;
   logic signed [N_W-1:0]     b1_n_ff;
   logic [M_W-1:0]            b1_m_ff, b1_m_in;
   logic [M_W-1:0]            prio_wide;
   logic [P_W-1:0]            prio_ext;
   logic [PRIO_W-1:0]         b1_prio_ff, b1_prio_in;
   region_type                b1_region_ff;
   logic                      b1_last_ff;

   assign pop        = !empty;
   assign b1_prod_in = $signed(head.n_val) * $signed(head.width_deriv);
   assign b1_dsb_in  = $signed(head.state_deriv) - $signed(head.bound_deriv);

   always_comb begin
      case (head.region)
         REGION_LINEAR: begin
            b1_m_in   = M_ONE;
            prio_wide = '0;
         end
         REGION_QUAD: begin
            b1_m_in   = M_W'(M_ONE - head.n_val[M_W-1:0]);
            prio_wide = head.n_val[M_W-1:0];
         end
         REGION_ZERO: begin
            b1_m_in   = '0;
            prio_wide = M_ONE;
         end
         default: begin
            b1_m_in   = '0;
            prio_wide = '0;
         end
      endcase
      prio_ext   = P_W'(prio_wide);
      b1_prio_in = PRIO_W'((prio_ext > PRIO_MAX) ? PRIO_MAX : prio_ext);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= !empty;
      end
   end

   always_ff @(posedge clock) begin
      b1_prod_ff   <= b1_prod_in;
      b1_dsb_ff    <= b1_dsb_in;
      b1_n_ff      <= head.n_val;
      b1_m_ff      <= b1_m_in;
      b1_prio_ff   <= b1_prio_in;
      b1_region_ff <= head.region;
      b1_last_ff   <= head.last_elem;
   end

   // stage 2: chain numerator u and the cost
   logic signed [PROD_W-1:0]  prod_floor;
   logic signed [U_W-1:0]     u_full;
   logic [U_W-1:0]            u_abs;
   logic [U_MAG_W-1:0]        b2_umag_ff, b2_umag_in;
   logic                      b2_uneg_ff;
   logic [DATA_W-1:0]         n_abs;
   logic [LIN_W-1:0]          lin_sum;
   logic [SQ_W-1:0]           m_sq;
   logic [COST_W-1:0]         b2_cost_ff, b2_cost_in;
   logic                      b2_valid_ff;
   logic [M_W-1:0]            b2_m_ff;
   logic [PRIO_W-1:0]         b2_prio_ff;
   region_type                b2_region_ff;
   logic                      b2_last_ff;

   assign prod_floor = b1_prod_ff >>> FRAC_BITS;
   assign u_full     = b1_dsb_ff - prod_floor;
   assign u_abs      = u_full[U_W-1] ? U_W'(~u_full + 1'b1) : u_full;
   assign b2_umag_in = (|u_abs[U_W-1:U_MAG_W]) ? U_MAX : u_abs[U_MAG_W-1:0];
   assign n_abs      = DATA_W'(-b1_n_ff);
   assign lin_sum    = LIN_ONE + {2'b00, n_abs, 1'b0};
   assign m_sq       = b1_m_ff * b1_m_ff;

   always_comb begin
      case (b1_region_ff)
         REGION_LINEAR: b2_cost_in = (lin_sum > LIN_W'(COST_MAX)) ? COST_MAX
                                                                  : lin_sum[COST_W-1:0];
         REGION_QUAD:   b2_cost_in = COST_W'(m_sq >> FRAC_BITS);
         default:       b2_cost_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b2_valid_ff <= 1'b0;
      end else begin
         b2_valid_ff <= b1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b2_umag_ff   <= b2_umag_in;
      b2_uneg_ff   <= u_full[U_W-1];
      b2_cost_ff   <= b2_cost_in;
      b2_m_ff      <= b1_m_ff;
      b2_prio_ff   <= b1_prio_ff;
      b2_region_ff <= b1_region_ff;
      b2_last_ff   <= b1_last_ff;
   end

   // stage 3: m times |u| as the jacobian numerator
   logic [M_W+U_MAG_W-1:0] mu_full;
   logic                   b3_valid_ff;
   logic [MU_W-1:0]        b3_mu_ff;
   back_tag_type           b3_tag_ff, b3_tag_in;

   assign mu_full = b2_m_ff * b2_umag_ff;

   always_comb begin
      b3_tag_in.u_neg     = b2_uneg_ff;
      b3_tag_in.region    = b2_region_ff;
      b3_tag_in.cost      = b2_cost_ff;
      b3_tag_in.prio      = b2_prio_ff;
      b3_tag_in.last_elem = b2_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b3_valid_ff <= 1'b0;
      end else begin
         b3_valid_ff <= b2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b3_mu_ff  <= mu_full[MU_W-1:0];
      b3_tag_ff <= b3_tag_in;
   end

   // jacobian quotient over the width
   logic              div_valid;
   logic [MU_W-1:0]   div_quo;
   logic [TAG_W-1:0]  div_tag_bits;
   back_tag_type      div_tag;

   hscc_div #(
      .NUM_W (MU_W),
      .DEN_W (WIDTH_W),
      .TAG_W (TAG_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b3_valid_ff),
      .in_num    (b3_mu_ff),
      .in_tag    (b3_tag_ff),
      .den       (cfg.width),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_tag   (div_tag_bits)
   );

   assign div_tag = back_tag_type'(div_tag_bits);

   // saturate, apply -2 * sign and saturate again
   logic [DATA_W:0]           q_mag;
   logic [DATA_W+1:0]         j_mag;
   logic                      j_neg;
   logic signed [DATA_W-1:0]  deriv_in;
   logic                      out_valid_ff;
   logic [COST_W-1:0]         cost_ff;
   logic signed [DATA_W-1:0]  deriv_ff;
   logic [PRIO_W-1:0]         prio_ff;
   logic                      last_ff;

   assign q_mag = (div_quo > Q_LIM_W) ? Q_LIM : div_quo[DATA_W:0];
   assign j_mag = {q_mag, 1'b0};
   assign j_neg = ~(div_tag.u_neg ^ cfg.upper);

   always_comb begin
      if (div_tag.region == REGION_ZERO) begin
         deriv_in = '0;
      end else if (j_neg) begin
         deriv_in = (j_mag > JNEG_MAX) ? DATA_W'(JNEG_MAX) : DATA_W'(~j_mag + 1'b1);
      end else begin
         deriv_in = (j_mag > JPOS_MAX) ? DATA_W'(JPOS_MAX) : j_mag[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      cost_ff  <= div_tag.cost;
      deriv_ff <= deriv_in;
      prio_ff  <= div_tag.prio;
      last_ff  <= div_tag.last_elem;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_cost       = cost_ff;
   assign rsp_cost_deriv = deriv_ff;
   assign rsp_norm_sat   = prio_ff;
   assign rsp_last_out   = last_ff;

   // each entry taken from the queue gives one strobe after stages 1 to 3, the divider and the output register
   a_back_latency: assert property (@(posedge clock) disable iff (reset)
      pop |-> ##BACK_LAT rsp_valid)
      else $error("back part lost a beat");

endmodule

`default_nettype wire

/* hw/rtl/huber_soft_constraint_cost.sv */
// top level of the huber soft constraint cost block
`default_nettype none

// Huber soft constraint cost in signed fixed point with FRAC_BITS fraction bits.
// One item is taken per clock cycle (start high while busy is low) and each item
// gives exactly one result, shown on the rsp_ ports for a single cycle under
// rsp_valid. At the default FRAC_BITS the format is Q16.16. The two pipelined
// restoring dividers produce one quotient bit per stage: 32+FRAC_BITS stages for
// the normalised state and 33+FRAC_BITS for the jacobian element. Results cannot
// be held off; the queue between the front and back parts drains every cycle, so
// busy stays low in normal use. csr_ready is always high; the user must write
// registers only while no item is in flight; the block does not enforce it.
module huber_soft_constraint_cost #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic signed [hscc_pkg::DATA_W-1:0]       req_state_value,
   input  logic signed [hscc_pkg::DATA_W-1:0]       req_state_deriv,
   input  logic signed [hscc_pkg::DATA_W-1:0]       req_bound_deriv,
   input  logic signed [hscc_pkg::DATA_W-1:0]       req_width_deriv,
   input  logic                                     req_last_elem,
   output logic                                     rsp_valid,
   output logic [hscc_pkg::COST_W-1:0]              rsp_cost,
   output logic signed [hscc_pkg::DATA_W-1:0]       rsp_cost_deriv,
   output logic [hscc_pkg::PRIO_W-1:0]              rsp_norm_sat,
   output logic                                     rsp_last_out,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [hscc_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [hscc_pkg::DATA_W-1:0]              csr_wdata
);

   import hscc_pkg::*;

   localparam logic [DATA_W-1:0]  BOUND_RESET = DATA_W'(1) << FRAC_BITS;
   localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(1) << FRAC_BITS;
   localparam int TOTAL_LAT = 2 * FRAC_BITS + 72;

   logic signed [DATA_W-1:0] bound_ff, bound_in;
   logic [WIDTH_W-1:0]       width_ff, width_in;
   logic                     upper_ff, upper_in;
   cfg_type                  cfg;
   logic                     accept;
   logic                     fifo_push, fifo_pop, fifo_empty, fifo_full;
   entry_type                fifo_in, fifo_head;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      bound_in = bound_ff;
      width_in = width_ff;
      upper_in = upper_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BOUND: bound_in = csr_wdata;
            CSR_WIDTH: width_in = csr_wdata[WIDTH_W-1:0];
            CSR_UPPER: upper_in = csr_wdata[0];
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bound_ff <= BOUND_RESET;
         width_ff <= WIDTH_RESET;
         upper_ff <= 1'b0;
      end else begin
         bound_ff <= bound_in;
         width_ff <= width_in;
         upper_ff <= upper_in;
      end
   end

   // a zero width counts as one lsb
   always_comb begin
      cfg.bound = bound_ff;
      cfg.width = (width_ff == '0) ? WIDTH_W'(1) : width_ff;
      cfg.upper = upper_ff;
   end

   assign busy   = fifo_full;
   assign accept = start && !busy;

   hscc_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (accept),
      .state_value (req_state_value),
      .state_deriv (req_state_deriv),
      .bound_deriv (req_bound_deriv),
      .width_deriv (req_width_deriv),
      .last_elem   (req_last_elem),
      .cfg         (cfg),
      .push        (fifo_push),
      .push_data   (fifo_in)
   );

   hscc_fifo #(
      .DEPTH (4)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (fifo_in),
      .pop       (fifo_pop),
      .head      (fifo_head),
      .empty     (fifo_empty),
      .full      (fifo_full)
   );

   hscc_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .empty          (fifo_empty),
      .head           (fifo_head),
      .cfg            (cfg),
      .pop            (fifo_pop),
      .rsp_valid      (rsp_valid),
      .rsp_cost       (rsp_cost),
      .rsp_cost_deriv (rsp_cost_deriv),
      .rsp_norm_sat   (rsp_norm_sat),
      .rsp_last_out   (rsp_last_out)
   );

   // every accepted item gives its strobe after passing the front, the queue and the back part
   a_total_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##TOTAL_LAT rsp_valid)
      else $error("accepted item produced no result");

endmodule

`default_nettype wire
